>>> src/tpts_pkg.sv
// Shared types, codes and constants for the temperature probe threshold switch.
// No dependencies; the front, back and top-level files import this package.
package tpts_pkg;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_PROBE = 2'd1;
    localparam logic [1:0] ERR_BAD_CRC  = 2'd2;
    localparam logic [1:0] ERR_FAMILY   = 2'd3;

    localparam logic [1:0] MODE_INSIDE  = 2'd0;
    localparam logic [1:0] MODE_ABOVE   = 2'd1;
    localparam logic [1:0] MODE_BELOW   = 2'd2;
    localparam logic [1:0] MODE_OUTSIDE = 2'd3;

    localparam logic [1:0] REG_USE_FAHRENHEIT = 2'd0;
    localparam logic [1:0] REG_LOW_TARGET     = 2'd1;
    localparam logic [1:0] REG_HIGH_TARGET    = 2'd2;
    localparam logic [1:0] REG_WINDOW_MODE    = 2'd3;

    localparam logic [7:0] FAMILY_A = 8'h10;
    localparam logic [7:0] FAMILY_B = 8'h28;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam int         CRC_BITS = 56;

    // -1000 degrees in sixteenths
    localparam logic signed [16:0] ERR_TEMP = -17'sd16000;
    // 32 degrees * 16 sixteenths * 5, added before the divide by 5
    localparam logic signed [19:0] FAHR_OFFSET = 20'sd2560;
    // floor(a / 5) == (a * DIV5_MUL) >> DIV5_SHIFT for every a below 2**19
    localparam logic [18:0] DIV5_MUL   = 19'd419431;
    localparam int          DIV5_SHIFT = 21;

    typedef struct packed {
        logic                use_fahrenheit;
        logic signed [16:0]  low_target;
        logic signed [16:0]  high_target;
        logic [1:0]          window_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          err;
        logic signed [15:0]  raw;
        logic                n_neg;
        logic [18:0]         n_abs;
    } front_item_t;

    typedef struct packed {
        logic signed [16:0]  temperature;
        logic [1:0]          error_code;
        logic                switch_on;
    } result_t;

    // CRC-8 contribution of ROM bit k alone; the CRC is linear with zero start,
    // so the full CRC is the XOR of the columns of the set bits.
    function automatic logic [7:0] crc_column(input int k);
        logic [7:0] crc;
        logic       mix;
        crc = 8'h00;
        for (int j = 0; j < CRC_BITS; j++)
        begin
            mix = crc[0] ^ (j == k);
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

>>> src/tpts_fifo.sv
// Small first-word-fall-through queue, used between front and back and on the
// result side. Depends on nothing; DEPTH must be at least 2.
module tpts_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/tpts_front.sv
// Front end: takes probe readings, checks ROM CRC and family, sets the error
// code and prepares the Fahrenheit dividend. Depends on tpts_pkg.
module tpts_front
    import tpts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               probe_found,
    input  logic [63:0]        rom_code,
    input  logic signed [15:0] raw_reading,
    output logic               item_valid,
    input  logic               item_ready,
    output front_item_t        item
);

    logic        valid_reg, valid_next;
    front_item_t item_reg, item_next;
    logic        accept;
    logic [7:0]  crc;
    logic [7:0]  family;
    logic signed [19:0] raw_ext;
    logic signed [19:0] dividend;

    assign full       = valid_reg && !item_ready;
    assign accept     = push && !full;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign family     = rom_code[7:0];

    always_comb
    begin
        crc = 8'h00;
        for (int k = 0; k < CRC_BITS; k++)
        begin
            if (rom_code[k])
            begin
                crc = crc ^ crc_column(k);
            end
        end
    end

    always_comb
    begin
        raw_ext  = 20'(raw_reading);
        dividend = (raw_ext <<< 3) + raw_ext + FAHR_OFFSET;

        item_next.raw   = raw_reading;
        item_next.n_neg = dividend[19];
        item_next.n_abs = dividend[19] ? 19'(-dividend) : dividend[18:0];

        if (!probe_found)
        begin
            item_next.err = ERR_NO_PROBE;
        end
        else if (crc != rom_code[63:56])
        begin
            item_next.err = ERR_BAD_CRC;
        end
        else if (family != FAMILY_A && family != FAMILY_B)
        begin
            item_next.err = ERR_FAMILY;
        end
        else
        begin
            item_next.err = ERR_NONE;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> src/tpts_back.sv
// Back end: divides by 5 through a reciprocal multiply, picks the unit, applies
// the window mode and keeps the switch state. Depends on tpts_pkg.
module tpts_back
    import tpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_pop,
    input  front_item_t in_item,
    output logic        res_push,
    input  logic        res_full,
    output result_t     res
);

    localparam int PROD_W = 38;

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_err_reg;
    logic signed [15:0] s1_raw_reg;
    logic              s1_neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              state_reg, state_next;
    logic [16:0]       quot;
    logic signed [16:0] temp;
    logic              below, above;

    assign res_push = s1_valid_reg && !res_full;
    assign in_pop   = in_valid && (!s1_valid_reg || !res_full);

    always_comb
    begin
        if (in_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        quot = prod_reg[DIV5_SHIFT +: 17];
        if (s1_err_reg != ERR_NONE)
        begin
            temp = ERR_TEMP;
        end
        else if (cfg.use_fahrenheit)
        begin
            // round toward zero: divide the magnitude, then restore the sign
            temp = s1_neg_reg ? -$signed(quot) : $signed(quot);
        end
        else
        begin
            temp = 17'(s1_raw_reg);
        end

        below = temp < cfg.low_target;
        above = temp > cfg.high_target;

        case (cfg.window_mode)
            MODE_INSIDE:
            begin
                state_next = !(below || above);
            end
            MODE_ABOVE:
            begin
                if (below)
                begin
                    state_next = 1'b0;
                end
                else if (above)
                begin
                    state_next = 1'b1;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            MODE_BELOW:
            begin
                if (below)
                begin
                    state_next = 1'b1;
                end
                else if (above)
                begin
                    state_next = 1'b0;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            default:
            begin
                state_next = below || above;
            end
        endcase

        res.temperature = temp;
        res.error_code  = s1_err_reg;
        res.switch_on   = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (res_push)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            s1_err_reg <= in_item.err;
            s1_raw_reg <= in_item.raw;
            s1_neg_reg <= in_item.n_neg;
            prod_reg   <= PROD_W'(in_item.n_abs) * PROD_W'(DIV5_MUL);
        end
    end

endmodule

>>> src/temp_probe_threshold_switch.sv
// Temperature probe threshold switch, top level.
// Channels: readings enter on push/full (accepted when push is high and full is
// low); results leave on empty/pop, the oldest result shown while empty is low
// and taken when pop is high. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// Register indexes: 0 use_fahrenheit, 1 low_target, 2 high_target, 3 window_mode.
// Throughput: one reading per cycle, sustained, as long as results are popped.
// A pushed reading is held in the front register, then passes the front-to-back
// queue, the multiply stage and the result queue before it shows on the ports.
// The reciprocal multiply for the Fahrenheit divide sets the stage split.
// When the receiver stalls, the result queue fills, then the multiply stage and
// the middle queue hold, and full rises only once the front register is stuck.
// The switch state advances only as results enter the result queue, so stalls
// never change the result sequence.
// Reset clears all queues, the switch state (off) and the configuration to
// Fahrenheit with both bounds 0 and window mode inside-window.
// Depends on tpts_pkg, tpts_front, tpts_back and tpts_fifo.
module temp_probe_threshold_switch
    import tpts_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               probe_found,
    input  logic [63:0]        rom_code,
    input  logic signed [15:0] raw_reading,
    output logic               empty,
    input  logic               pop,
    output logic signed [16:0] temperature,
    output logic [1:0]         error_code,
    output logic               switch_on,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int MID_W = $bits(front_item_t);
    localparam int RES_W = $bits(result_t);

    cfg_t        cfg_reg, cfg_next;
    logic        front_valid, mid_full, mid_empty, back_pop;
    front_item_t front_item, mid_item;
    logic        res_push, res_full;
    result_t     back_res, res_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_USE_FAHRENHEIT: cfg_next.use_fahrenheit = cfg_data[0];
                REG_LOW_TARGET:     cfg_next.low_target     = $signed(cfg_data);
                REG_HIGH_TARGET:    cfg_next.high_target    = $signed(cfg_data);
                REG_WINDOW_MODE:    cfg_next.window_mode    = cfg_data[1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_fahrenheit <= 1'b1;
            cfg_reg.low_target     <= '0;
            cfg_reg.high_target    <= '0;
            cfg_reg.window_mode    <= MODE_INSIDE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .probe_found (probe_found),
        .rom_code    (rom_code),
        .raw_reading (raw_reading),
        .item_valid  (front_valid),
        .item_ready  (!mid_full),
        .item        (front_item)
    );

    tpts_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (MID_W)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (back_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    tpts_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (!mid_empty),
        .in_pop   (back_pop),
        .in_item  (mid_item),
        .res_push (res_push),
        .res_full (res_full),
        .res      (back_res)
    );

    tpts_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH (RES_W)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign temperature = res_head.temperature;
    assign error_code  = res_head.error_code;
    assign switch_on   = res_head.switch_on;

endmodule
